// ----- src/gcb_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the glyph coverage blender.
package gcb_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned IN_DATA_W = 40;
  localparam int unsigned OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_FG_COLOR     = 2'd0,
    REG_BG_COLOR     = 2'd1,
    REG_PIXEL_FORMAT = 2'd2,
    REG_BLEND_MODE   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    FMT_RGB565   = 2'd0,
    FMT_ARGB1555 = 2'd1,
    FMT_ARGB8888 = 2'd2,
    FMT_UNUSED   = 2'd3
  } pix_fmt_t;

  typedef enum logic {
    MODE_COVER = 1'b0,
    MODE_ALPHA = 1'b1
  } blend_mode_t;

  typedef enum logic [2:0] {
    KIND_PASS,
    KIND_RGB565,
    KIND_ARGB1555,
    KIND_ARGB8888,
    KIND_FG_COPY
  } blend_kind_t;

  localparam logic [7:0] COV_EMPTY = 8'h00;
  localparam logic [7:0] COV_FULL  = 8'hFF;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

endpackage

// ----- src/glyph_coverage_blend_top.sv -----
`timescale 1ns / 1ps
// Glyph coverage blender: four-stage pixel pipeline with an APB register port.
//
// Usage:
//   Input stream s_*: one transaction per pixel; s_tdata carries the 8-bit
//   glyph coverage and the 32-bit destination pixel.
//   Output stream m_*: one transaction per input; m_tdata is the pixel to
//   store, m_tuser is the write enable for the framebuffer.
//   APB port: fg_color at 0x0, bg_color at 0x4, pixel_format at 0x8,
//   blend_mode at 0xC; write only while the pipeline is empty.
// Timing:
//   Four register stages (capture, channel select, multiply, sum and pack).
//   An accepted input passes the capture, channel select, multiply and sum
//   and pack registers; while m_tready is high, one pixel is taken per cycle,
//   since every stage advances whenever its successor can take its contents.
// Reset:
//   Synchronous rst empties the pipeline and clears the configuration registers to zero.
// Backpressure:
//   When m_tready is low, stages fill from the output backward; s_tready
//   drops only once all four stages hold a pixel. Nothing is lost or repeated.
module glyph_coverage_blend_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [7:0] coverage, [39:8] dest_pixel
  input  logic [gcb_pkg::IN_DATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [31:0] pixel_out
  output logic [gcb_pkg::OUT_DATA_W-1:0] m_tdata,
  // [0] write_enable
  output logic                          m_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gcb_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [31:0]          fg_color;
  logic [31:0]          bg_color;
  gcb_pkg::pix_fmt_t    pixel_format;
  gcb_pkg::blend_mode_t blend_mode;
  gcb_pkg::reg_idx_t    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = gcb_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color     <= '0;
      bg_color     <= '0;
      pixel_format <= gcb_pkg::FMT_RGB565;
      blend_mode   <= gcb_pkg::MODE_COVER;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        gcb_pkg::REG_FG_COLOR:     fg_color <= pwdata;
        gcb_pkg::REG_BG_COLOR:     bg_color <= pwdata;
        gcb_pkg::REG_PIXEL_FORMAT: pixel_format <= gcb_pkg::pix_fmt_t'(pwdata[1:0]);
        gcb_pkg::REG_BLEND_MODE:   blend_mode <= gcb_pkg::blend_mode_t'(pwdata[0]);
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      gcb_pkg::REG_FG_COLOR:     prdata = fg_color;
      gcb_pkg::REG_BG_COLOR:     prdata = bg_color;
      gcb_pkg::REG_PIXEL_FORMAT: prdata = {30'd0, pixel_format};
      gcb_pkg::REG_BLEND_MODE:   prdata = {31'd0, blend_mode};
    endcase
  end

  // Stage ready chain
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4 || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  // Stage 1: capture
  logic [7:0]  cov1;
  logic [31:0] dst1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      cov1 <= s_tdata[7:0];
      dst1 <= s_tdata[39:8];
    end
  end

  // Stage 2: channel select and weights
  logic [31:0]          base1;
  gcb_pkg::blend_kind_t kind1;
  logic [7:0]           bch1 [0:2];
  logic [7:0]           fch1 [0:2];
  logic [7:0]           wgt1;

  always_comb begin
    base1 = (blend_mode == gcb_pkg::MODE_ALPHA) ? dst1 : bg_color;
    kind1 = gcb_pkg::KIND_PASS;
    if (cov1 != gcb_pkg::COV_EMPTY) begin
      unique case (pixel_format)
        gcb_pkg::FMT_RGB565:   kind1 = gcb_pkg::KIND_RGB565;
        gcb_pkg::FMT_ARGB1555: kind1 = gcb_pkg::KIND_ARGB1555;
        gcb_pkg::FMT_ARGB8888: kind1 = (cov1 == gcb_pkg::COV_FULL) ?
                                       gcb_pkg::KIND_FG_COPY : gcb_pkg::KIND_ARGB8888;
        default:               kind1 = gcb_pkg::KIND_PASS;
      endcase
    end
    unique case (pixel_format)
      gcb_pkg::FMT_RGB565: begin
        bch1[0] = {3'd0, base1[15:11]};
        bch1[1] = {2'd0, base1[10:5]};
        bch1[2] = {3'd0, base1[4:0]};
        fch1[0] = {3'd0, fg_color[15:11]};
        fch1[1] = {2'd0, fg_color[10:5]};
        fch1[2] = {3'd0, fg_color[4:0]};
        wgt1    = 8'd0 - cov1;
      end
      gcb_pkg::FMT_ARGB1555: begin
        bch1[0] = {3'd0, base1[14:10]};
        bch1[1] = {3'd0, base1[9:5]};
        bch1[2] = {3'd0, base1[4:0]};
        fch1[0] = {3'd0, fg_color[14:10]};
        fch1[1] = {3'd0, fg_color[9:5]};
        fch1[2] = {3'd0, fg_color[4:0]};
        wgt1    = 8'd0 - cov1;
      end
      default: begin
        bch1[0] = base1[23:16];
        bch1[1] = base1[15:8];
        bch1[2] = base1[7:0];
        fch1[0] = fg_color[23:16];
        fch1[1] = fg_color[15:8];
        fch1[2] = fg_color[7:0];
        wgt1    = ~cov1;
      end
    endcase
  end

  logic [7:0]           cov2;
  logic [31:0]          dst2;
  gcb_pkg::blend_kind_t kind2;
  logic [7:0]           bch2 [0:2];
  logic [7:0]           fch2 [0:2];
  logic [7:0]           wgt2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      cov2  <= cov1;
      dst2  <= dst1;
      kind2 <= kind1;
      wgt2  <= wgt1;
      for (int i = 0; i < 3; i++) begin
        bch2[i] <= bch1[i];
        fch2[i] <= fch1[i];
      end
    end
  end

  // Stage 3: channel products
  logic [31:0]          dst3;
  gcb_pkg::blend_kind_t kind3;
  logic [15:0]          pb3 [0:2];
  logic [15:0]          pf3 [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      dst3  <= dst2;
      kind3 <= kind2;
      for (int i = 0; i < 3; i++) begin
        pb3[i] <= bch2[i] * wgt2;
        pf3[i] <= fch2[i] * cov2;
      end
    end
  end

  // Stage 4: sum, scale and pack
  logic [16:0] sum3 [0:2];
  logic [7:0]  ch3  [0:2];
  logic [31:0] pix3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum3[i] = {1'b0, pb3[i]} + {1'b0, pf3[i]};
      ch3[i]  = sum3[i][15:8];
    end
    unique case (kind3)
      gcb_pkg::KIND_RGB565:   pix3 = {16'd0, ch3[0][4:0], ch3[1][5:0], ch3[2][4:0]};
      gcb_pkg::KIND_ARGB1555: pix3 = {16'd0, fg_color[15], ch3[0][4:0], ch3[1][4:0],
                                      ch3[2][4:0]};
      gcb_pkg::KIND_ARGB8888: pix3 = {gcb_pkg::ALPHA_OPAQUE, ch3[0], ch3[1], ch3[2]};
      gcb_pkg::KIND_FG_COPY:  pix3 = fg_color;
      default:                pix3 = dst3;
    endcase
  end

  logic [31:0] pix4;
  logic        we4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      pix4 <= pix3;
      we4  <= (kind3 != gcb_pkg::KIND_PASS);
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = pix4;
  assign m_tuser  = we4;

endmodule
